@@ rtl/stt_pkg.sv @@
// shared types, constants and helper functions of the source text tokenizer
`default_nettype none

package stt_pkg;

	// token kinds
	localparam logic [4:0] K_EOF     = 5'd0;
	localparam logic [4:0] K_LPAREN  = 5'd1;
	localparam logic [4:0] K_RPAREN  = 5'd2;
	localparam logic [4:0] K_LBRACE  = 5'd3;
	localparam logic [4:0] K_RBRACE  = 5'd4;
	localparam logic [4:0] K_LBRACK  = 5'd5;
	localparam logic [4:0] K_RBRACK  = 5'd6;
	localparam logic [4:0] K_PLUS    = 5'd7;
	localparam logic [4:0] K_MINUS   = 5'd8;
	localparam logic [4:0] K_STAR    = 5'd9;
	localparam logic [4:0] K_SLASH   = 5'd10;
	localparam logic [4:0] K_SEMI    = 5'd11;
	localparam logic [4:0] K_COMMA   = 5'd12;
	localparam logic [4:0] K_DOT     = 5'd13;
	localparam logic [4:0] K_ASSIGN  = 5'd14;
	localparam logic [4:0] K_GT      = 5'd15;
	localparam logic [4:0] K_LT      = 5'd16;
	localparam logic [4:0] K_NOT     = 5'd17;
	localparam logic [4:0] K_STRING  = 5'd18;
	localparam logic [4:0] K_IDENT   = 5'd19;
	localparam logic [4:0] K_FOR     = 5'd20;
	localparam logic [4:0] K_WHILE   = 5'd21;
	localparam logic [4:0] K_RETURN  = 5'd22;
	localparam logic [4:0] K_NEW     = 5'd23;
	localparam logic [4:0] K_DELETE  = 5'd24;
	localparam logic [4:0] K_NULL    = 5'd25;
	localparam logic [4:0] K_BOOL    = 5'd26;
	localparam logic [4:0] K_DIGIT   = 5'd27;
	localparam logic [4:0] K_FLOAT   = 5'd28;
	localparam logic [4:0] K_UNKNOWN = 5'd29;

	// special characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_VT    = 8'h0b;
	localparam logic [7:0] CH_FF    = 8'h0c;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_TICK  = 8'h60;
	localparam logic [7:0] CH_UNDER = 8'h5f;
	localparam logic [7:0] CH_DOT   = 8'h2e;

	// packed keyword text, first byte most significant
	localparam logic [47:0] KW_FOR    = 48'h0000_0066_6f72;
	localparam logic [47:0] KW_WHILE  = 48'h0077_6869_6c65;
	localparam logic [47:0] KW_RETURN = 48'h7265_7475_726e;
	localparam logic [47:0] KW_NEW    = 48'h0000_006e_6577;
	localparam logic [47:0] KW_DELETE = 48'h6465_6c65_7465;
	localparam logic [47:0] KW_NULL   = 48'h0000_6e75_6c6c;
	localparam logic [47:0] KW_TRUE   = 48'h0000_7472_7565;
	localparam logic [47:0] KW_FALSE  = 48'h0066_616c_7365;

	localparam logic [2:0] KW_MAX_LEN = 3'd6;
	localparam logic [2:0] KW_SAT_LEN = 3'd7;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [7:0] {
		M_IDLE     = 8'b0000_0001,
		M_IDENT    = 8'b0000_0010,
		M_NUMBER   = 8'b0000_0100,
		M_STRING   = 8'b0000_1000,
		M_AT       = 8'b0001_0000,
		M_LINE     = 8'b0010_0000,
		M_BLOCK    = 8'b0100_0000,
		M_BLOCK_AT = 8'b1000_0000
	} mode_t;

	typedef struct packed {
		logic       is_token_end;
		logic [4:0] token_kind;
		logic [7:0] text_byte;
	} res_t;

	// results of one item: first always present, second when two is set
	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} entry_t;

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_FF || c == CH_VT || c == CH_LF;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic [4:0] ident_kind(input logic [47:0] kbuf, input logic [2:0] klen);
		logic [4:0] k;
		k = K_IDENT;
		if (klen == 3'd3 && kbuf == KW_FOR) k = K_FOR;
		else if (klen == 3'd5 && kbuf == KW_WHILE) k = K_WHILE;
		else if (klen == 3'd6 && kbuf == KW_RETURN) k = K_RETURN;
		else if (klen == 3'd3 && kbuf == KW_NEW) k = K_NEW;
		else if (klen == 3'd6 && kbuf == KW_DELETE) k = K_DELETE;
		else if (klen == 3'd4 && kbuf == KW_NULL) k = K_NULL;
		else if ((klen == 3'd4 && kbuf == KW_TRUE) || (klen == 3'd5 && kbuf == KW_FALSE))
			k = K_BOOL;
		return k;
	endfunction

	function automatic logic [4:0] single_kind(input logic [7:0] c);
		logic [4:0] k;
		unique case (c)
			8'h28:   k = K_LPAREN;
			8'h29:   k = K_RPAREN;
			8'h7b:   k = K_LBRACE;
			8'h7d:   k = K_RBRACE;
			8'h5b:   k = K_LBRACK;
			8'h5d:   k = K_RBRACK;
			8'h2b:   k = K_PLUS;
			8'h2d:   k = K_MINUS;
			8'h2a:   k = K_STAR;
			8'h2f:   k = K_SLASH;
			8'h3b:   k = K_SEMI;
			8'h2c:   k = K_COMMA;
			8'h2e:   k = K_DOT;
			8'h3d:   k = K_ASSIGN;
			8'h3e:   k = K_GT;
			8'h3c:   k = K_LT;
			8'h21:   k = K_NOT;
			default: k = K_UNKNOWN;
		endcase
		return k;
	endfunction

	function automatic res_t text_res(input logic [7:0] c);
		res_t r;
		r.is_token_end = 1'b0;
		r.token_kind   = K_EOF;
		r.text_byte    = c;
		return r;
	endfunction

	function automatic res_t end_res(input logic [4:0] k);
		res_t r;
		r.is_token_end = 1'b1;
		r.token_kind   = k;
		r.text_byte    = 8'h00;
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/stt_if.sv @@
// valid/ready channel interfaces for source bytes and token results
`default_nettype none

interface stt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_mark;

	modport source(output valid, output char_byte, output end_mark, input ready);
	modport sink(input valid, input char_byte, input end_mark, output ready);
endinterface

interface stt_out_if;
	logic       valid;
	logic       ready;
	logic       is_token_end;
	logic [4:0] token_kind;
	logic [7:0] text_byte;
	logic       last_of_item;

	modport source(output valid, output is_token_end, output token_kind, output text_byte,
		output last_of_item, input ready);
	modport sink(input valid, input is_token_end, input token_kind, input text_byte,
		input last_of_item, output ready);
endinterface

`default_nettype wire

@@ rtl/stt_front.sv @@
// front end: lexer mode machine, classifies each byte into up to two results
`default_nettype none

module stt_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	stt_in_if.sink             in_ch,
	input  wire logic          full,
	output stt_pkg::entry_t    entry,
	output logic               push
);

	stt_pkg::mode_t mode_q, mode_nxt;
	logic [47:0]    kbuf_q, kbuf_nxt;
	logic [2:0]     klen_q, klen_nxt;
	logic           float_q, float_nxt;
	logic           prevd_q, prevd_nxt;
	logic           done_q, done_nxt;

	logic           accept;
	logic           any;
	logic [7:0]     c;

	// what a byte does when seen from idle
	stt_pkg::mode_t sb_mode;
	logic           sb_has;
	stt_pkg::res_t  sb_res;
	logic           sb_done;
	logic           sb_ident;
	logic           sb_num;

	assign c           = in_ch.char_byte;
	assign in_ch.ready = !full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign push        = accept && !done_q && any;

	always_comb begin
		sb_mode  = stt_pkg::M_IDLE;
		sb_has   = 1'b0;
		sb_res   = stt_pkg::end_res(stt_pkg::K_EOF);
		sb_done  = 1'b0;
		sb_ident = 1'b0;
		sb_num   = 1'b0;
		if (c == stt_pkg::CH_NUL) begin
			sb_has  = 1'b1;
			sb_done = 1'b1;
		end else if (stt_pkg::is_space(c)) begin
			sb_has = 1'b0;
		end else if (c == stt_pkg::CH_AT) begin
			sb_mode = stt_pkg::M_AT;
		end else if (c == stt_pkg::CH_TICK) begin
			sb_mode = stt_pkg::M_STRING;
		end else if (stt_pkg::is_letter(c)) begin
			sb_mode  = stt_pkg::M_IDENT;
			sb_ident = 1'b1;
			sb_has   = 1'b1;
			sb_res   = stt_pkg::text_res(c);
		end else if (stt_pkg::is_digit(c)) begin
			sb_mode = stt_pkg::M_NUMBER;
			sb_num  = 1'b1;
			sb_has  = 1'b1;
			sb_res  = stt_pkg::text_res(c);
		end else begin
			sb_has = 1'b1;
			sb_res = stt_pkg::end_res(stt_pkg::single_kind(c));
		end
	end

	always_comb begin
		mode_nxt  = mode_q;
		kbuf_nxt  = kbuf_q;
		klen_nxt  = klen_q;
		float_nxt = float_q;
		prevd_nxt = prevd_q;
		done_nxt  = done_q;
		any       = 1'b0;
		entry.two = 1'b0;
		entry.r0  = stt_pkg::end_res(stt_pkg::K_EOF);
		entry.r1  = stt_pkg::end_res(stt_pkg::K_EOF);

		if (in_ch.end_mark) begin
			any      = 1'b1;
			mode_nxt = stt_pkg::M_IDLE;
			done_nxt = 1'b1;
			if (mode_q == stt_pkg::M_IDENT) begin
				entry.r0  = stt_pkg::end_res(stt_pkg::ident_kind(kbuf_q, klen_q));
				entry.two = 1'b1;
			end else if (mode_q == stt_pkg::M_NUMBER) begin
				entry.r0  = stt_pkg::end_res(float_q ? stt_pkg::K_FLOAT : stt_pkg::K_DIGIT);
				entry.two = 1'b1;
			end else if (mode_q == stt_pkg::M_STRING) begin
				entry.r0  = stt_pkg::end_res(stt_pkg::K_UNKNOWN);
				entry.two = 1'b1;
			end
		end else begin
			unique case (mode_q)
				stt_pkg::M_IDENT: begin
					if (stt_pkg::is_letter(c) || stt_pkg::is_digit(c) || c == stt_pkg::CH_UNDER)
					begin
						if (klen_q < stt_pkg::KW_MAX_LEN) begin
							kbuf_nxt = {kbuf_q[39:0], c};
							klen_nxt = klen_q + 3'd1;
						end else begin
							klen_nxt = stt_pkg::KW_SAT_LEN;
						end
						any      = 1'b1;
						entry.r0 = stt_pkg::text_res(c);
					end else begin
						any       = 1'b1;
						entry.r0  = stt_pkg::end_res(stt_pkg::ident_kind(kbuf_q, klen_q));
						entry.two = sb_has;
						entry.r1  = sb_res;
						mode_nxt  = sb_mode;
						if (sb_done) done_nxt = 1'b1;
						if (sb_ident) begin
							kbuf_nxt = {40'h0, c};
							klen_nxt = 3'd1;
						end
						if (sb_num) begin
							float_nxt = 1'b0;
							prevd_nxt = 1'b1;
						end
					end
				end
				stt_pkg::M_NUMBER: begin
					if (stt_pkg::is_digit(c)) begin
						prevd_nxt = 1'b1;
						any       = 1'b1;
						entry.r0  = stt_pkg::text_res(c);
					end else if (c == stt_pkg::CH_UNDER) begin
						prevd_nxt = 1'b0;
					end else if (c == stt_pkg::CH_DOT && prevd_q) begin
						float_nxt = 1'b1;
						prevd_nxt = 1'b0;
						any       = 1'b1;
						entry.r0  = stt_pkg::text_res(c);
					end else begin
						any       = 1'b1;
						entry.r0  = stt_pkg::end_res(float_q ? stt_pkg::K_FLOAT
							: stt_pkg::K_DIGIT);
						entry.two = sb_has;
						entry.r1  = sb_res;
						mode_nxt  = sb_mode;
						if (sb_done) done_nxt = 1'b1;
						if (sb_ident) begin
							kbuf_nxt = {40'h0, c};
							klen_nxt = 3'd1;
						end
						if (sb_num) begin
							float_nxt = 1'b0;
							prevd_nxt = 1'b1;
						end
					end
				end
				stt_pkg::M_STRING: begin
					any = 1'b1;
					if (c == stt_pkg::CH_TICK) begin
						entry.r0 = stt_pkg::end_res(stt_pkg::K_STRING);
						mode_nxt = stt_pkg::M_IDLE;
					end else begin
						entry.r0 = stt_pkg::text_res(c);
					end
				end
				stt_pkg::M_AT: begin
					if (c == stt_pkg::CH_AT) mode_nxt = stt_pkg::M_BLOCK;
					else if (c == stt_pkg::CH_LF || c == stt_pkg::CH_CR) mode_nxt = stt_pkg::M_IDLE;
					else mode_nxt = stt_pkg::M_LINE;
				end
				stt_pkg::M_LINE: begin
					if (c == stt_pkg::CH_LF || c == stt_pkg::CH_CR) mode_nxt = stt_pkg::M_IDLE;
				end
				stt_pkg::M_BLOCK: begin
					if (c == stt_pkg::CH_AT) mode_nxt = stt_pkg::M_BLOCK_AT;
				end
				stt_pkg::M_BLOCK_AT: begin
					mode_nxt = (c == stt_pkg::CH_AT) ? stt_pkg::M_IDLE : stt_pkg::M_BLOCK;
				end
				default: begin
					any      = sb_has;
					entry.r0 = sb_res;
					mode_nxt = sb_mode;
					if (sb_done) done_nxt = 1'b1;
					if (sb_ident) begin
						kbuf_nxt = {40'h0, c};
						klen_nxt = 3'd1;
					end
					if (sb_num) begin
						float_nxt = 1'b0;
						prevd_nxt = 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= stt_pkg::M_IDLE;
			kbuf_q  <= '0;
			klen_q  <= '0;
			float_q <= 1'b0;
			prevd_q <= 1'b0;
			done_q  <= 1'b0;
		end else if (accept && !done_q) begin
			mode_q  <= mode_nxt;
			kbuf_q  <= kbuf_nxt;
			klen_q  <= klen_nxt;
			float_q <= float_nxt;
			prevd_q <= prevd_nxt;
			done_q  <= done_nxt;
		end
	end

endmodule

`default_nettype wire

@@ rtl/stt_queue.sv @@
// short result queue between the lexer front end and the output back end
`default_nettype none

module stt_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire stt_pkg::entry_t   wr_entry,
	input  wire logic              pop,
	output stt_pkg::entry_t        head,
	output logic                   full,
	output logic                   empty
);

	stt_pkg::entry_t             mem_q [stt_pkg::QUEUE_DEPTH];
	logic [stt_pkg::QPTR_W-1:0]  wr_q;
	logic [stt_pkg::QPTR_W-1:0]  rd_q;
	logic [stt_pkg::QCNT_W-1:0]  cnt_q;

	assign full  = cnt_q == stt_pkg::QCNT_W'(stt_pkg::QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == stt_pkg::QPTR_W'(stt_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_q + stt_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == stt_pkg::QPTR_W'(stt_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_q + stt_pkg::QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + stt_pkg::QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - stt_pkg::QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/stt_back.sv @@
// back end: unpacks queued entries into single results behind an output register
`default_nettype none

module stt_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              empty,
	input  wire stt_pkg::entry_t   head,
	output logic                   pop,
	stt_out_if.source              out_ch
);

	logic          valid_q;
	logic          sel_q;
	logic          load;
	logic          last;
	stt_pkg::res_t res_q;
	logic          last_q;

	// take the next result whenever the output register is free or draining
	assign load = !empty && (!valid_q || out_ch.ready);
	assign last = sel_q || !head.two;
	assign pop  = load && last;

	assign out_ch.valid        = valid_q;
	assign out_ch.is_token_end = res_q.is_token_end;
	assign out_ch.token_kind   = res_q.token_kind;
	assign out_ch.text_byte    = res_q.text_byte;
	assign out_ch.last_of_item = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sel_q   <= !last;
			end else if (out_ch.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= sel_q ? head.r1 : head.r0;
			last_q <= last;
		end
	end

	// second half of an entry is pending only while that entry is still at the head
	a_sel_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> !empty)
		else $error("second result pending with empty queue");

	a_sel_two: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> head.two)
		else $error("second result pending for a single-result entry");

	a_pop_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> valid_q && last_q)
		else $error("entry retired without its last result in the output register");

	a_sel_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !last) |=> sel_q && valid_q && !last_q)
		else $error("first of two results not followed by pending second");

endmodule

`default_nettype wire

@@ rtl/source_text_tokenizer.sv @@
// top level of the source text tokenizer: front end, result queue, back end
// path: the first result of an item is written to the queue and then loaded into the
// output register, when nothing is queued ahead of it and the output register is free
// throughput: one input item per cycle while the queue is not full; the output register
// gives one result per cycle while ready, so a two-result item sends them in turn
// the four-entry queue between the lexer front end and the output stage absorbs stalls
// reset: asynchronous, clears lexer mode, keyword matcher, end-of-stream flag and queue
`default_nettype none

module source_text_tokenizer (
	input  wire logic  clk,
	input  wire logic  arst_n,
	stt_in_if.sink     in_ch,
	stt_out_if.source  out_ch
);

	stt_pkg::entry_t push_entry;
	stt_pkg::entry_t head;
	logic            push;
	logic            pop;
	logic            full;
	logic            empty;

	stt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.full   (full),
		.entry  (push_entry),
		.push   (push)
	);

	stt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (push_entry),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	stt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

`default_nettype wire

@@ bench/token_checker.sv @@
`timescale 1ns / 1ps
// token checker: predicts tokenizer results from accepted source bytes and compares them
module token_checker import stt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	stt_in_if    in_ch,
	stt_out_if   out_ch,
	output int   errors,
	output int   pending
);

	typedef struct packed {
		logic       is_end;
		logic [4:0] kind;
		logic [7:0] text;
		logic       last;
	} token_res_t;

	token_res_t  expected_tokens[$];
	token_res_t  held_res;
	bit          held;
	int          fails = 0;

	mode_t       mode;
	logic [47:0] kw_buf;
	logic [2:0]  id_len;
	logic        num_float;
	logic        prev_digit;
	logic        done;

	assign errors = fails;

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_FF || c == CH_VT || c == CH_LF;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_num(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [4:0] op_kind(input logic [7:0] c);
		logic [4:0] k;
		case (c)
			"(":     k = K_LPAREN;
			")":     k = K_RPAREN;
			"{":     k = K_LBRACE;
			"}":     k = K_RBRACE;
			"[":     k = K_LBRACK;
			"]":     k = K_RBRACK;
			"+":     k = K_PLUS;
			"-":     k = K_MINUS;
			"*":     k = K_STAR;
			"/":     k = K_SLASH;
			";":     k = K_SEMI;
			",":     k = K_COMMA;
			".":     k = K_DOT;
			"=":     k = K_ASSIGN;
			">":     k = K_GT;
			"<":     k = K_LT;
			"!":     k = K_NOT;
			default: k = K_UNKNOWN;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] word_kind(input logic [47:0] w, input logic [2:0] n);
		logic [4:0] k;
		k = K_IDENT;
		case ({n, w})
			{3'd3, KW_FOR}:                     k = K_FOR;
			{3'd5, KW_WHILE}:                   k = K_WHILE;
			{3'd6, KW_RETURN}:                  k = K_RETURN;
			{3'd3, KW_NEW}:                     k = K_NEW;
			{3'd6, KW_DELETE}:                  k = K_DELETE;
			{3'd4, KW_NULL}:                    k = K_NULL;
			{3'd4, KW_TRUE}, {3'd5, KW_FALSE}:  k = K_BOOL;
			default: ;
		endcase
		return k;
	endfunction

	// the newest result is held back so the last one of a transaction can be marked
	task automatic emit(input logic e, input logic [4:0] k, input logic [7:0] t);
		if (held)
			expected_tokens.insert(expected_tokens.size(), held_res);
		held_res = '{e, k, t, 1'b0};
		held = 1'b1;
	endtask

	task automatic start_token(input logic [7:0] c);
		mode = M_IDLE;
		if (c == CH_NUL) begin
			emit(1'b1, K_EOF, 8'h00);
			done = 1'b1;
		end else if (is_blank(c)) begin
		end else if (c == CH_AT) begin
			mode = M_AT;
		end else if (c == CH_TICK) begin
			mode = M_STRING;
		end else if (is_alpha(c)) begin
			mode = M_IDENT;
			kw_buf = {40'h0, c};
			id_len = 3'd1;
			emit(1'b0, K_EOF, c);
		end else if (is_num(c)) begin
			mode = M_NUMBER;
			num_float = 1'b0;
			prev_digit = 1'b1;
			emit(1'b0, K_EOF, c);
		end else begin
			emit(1'b1, op_kind(c), 8'h00);
		end
	endtask

	task automatic close_stream();
		case (mode)
			M_IDENT:  emit(1'b1, word_kind(kw_buf, id_len), 8'h00);
			M_NUMBER: emit(1'b1, num_float ? K_FLOAT : K_DIGIT, 8'h00);
			M_STRING: emit(1'b1, K_UNKNOWN, 8'h00);
			default: ;
		endcase
		emit(1'b1, K_EOF, 8'h00);
		mode = M_IDLE;
		done = 1'b1;
	endtask

	task automatic lex_byte(input logic [7:0] c);
		case (mode)
			M_IDENT: begin
				if (is_alpha(c) || is_num(c) || c == CH_UNDER) begin
					if (id_len < KW_MAX_LEN) begin
						kw_buf = {kw_buf[39:0], c};
						id_len = id_len + 3'd1;
					end else begin
						id_len = KW_SAT_LEN;
					end
					emit(1'b0, K_EOF, c);
				end else begin
					emit(1'b1, word_kind(kw_buf, id_len), 8'h00);
					start_token(c);
				end
			end
			M_NUMBER: begin
				if (is_num(c)) begin
					prev_digit = 1'b1;
					emit(1'b0, K_EOF, c);
				end else if (c == CH_UNDER) begin
					prev_digit = 1'b0;
				end else if (c == CH_DOT && prev_digit) begin
					num_float = 1'b1;
					prev_digit = 1'b0;
					emit(1'b0, K_EOF, c);
				end else begin
					emit(1'b1, num_float ? K_FLOAT : K_DIGIT, 8'h00);
					start_token(c);
				end
			end
			M_STRING: begin
				if (c == CH_TICK) begin
					emit(1'b1, K_STRING, 8'h00);
					mode = M_IDLE;
				end else begin
					emit(1'b0, K_EOF, c);
				end
			end
			M_AT: begin
				if (c == CH_AT)
					mode = M_BLOCK;
				else if (c == CH_LF || c == CH_CR)
					mode = M_IDLE;
				else
					mode = M_LINE;
			end
			M_LINE: begin
				if (c == CH_LF || c == CH_CR)
					mode = M_IDLE;
			end
			M_BLOCK: begin
				if (c == CH_AT)
					mode = M_BLOCK_AT;
			end
			M_BLOCK_AT: begin
				mode = (c == CH_AT) ? M_IDLE : M_BLOCK;
			end
			default: start_token(c);
		endcase
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		token_res_t got;
		token_res_t want;
		if (!arst_n) begin
			mode = M_IDLE;
			kw_buf = '0;
			id_len = '0;
			num_float = 1'b0;
			prev_digit = 1'b0;
			done = 1'b0;
			held = 1'b0;
			expected_tokens.delete();
			pending <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.is_token_end, out_ch.token_kind, out_ch.text_byte,
					out_ch.last_of_item};
				if (expected_tokens.size() == 0) begin
					$error("result with none expected: is_token_end=%0b token_kind=%0d text_byte=%0d",
						got.is_end, got.kind, got.text);
					fails++;
				end else begin
					want = expected_tokens.pop_front();
					check_field("is_token_end", want.is_end, got.is_end);
					check_field("token_kind", want.kind, got.kind);
					check_field("text_byte", want.text, got.text);
					check_field("last_of_item", want.last, got.last);
				end
			end
			// after end of stream every transaction is dropped without a result
			if (in_ch.valid && in_ch.ready && !done) begin
				if (in_ch.end_mark)
					close_stream();
				else
					lex_byte(in_ch.char_byte);
				if (held) begin
					held_res.last = 1'b1;
					expected_tokens.insert(expected_tokens.size(), held_res);
					held = 1'b0;
				end
			end
			pending <= expected_tokens.size();
		end
	end

endmodule

@@ bench/tb_source_text_tokenizer.sv @@
`timescale 1ns / 1ps
// testbench top: source byte stream in bursts, stalling token sink, run verdict
module tb_source_text_tokenizer;
	import stt_pkg::*;

	localparam int STREAM_LEN  = 1200;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_LIMIT = 5000;
	localparam int SETTLE      = 10;
	localparam int TAIL_ITEMS  = 6;

	typedef struct packed {
		logic [7:0] ch;
		logic       eos;
	} src_item_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_style_t;

	logic        clk = 1'b0;
	logic        arst_n;
	int          errors;
	int          pending;
	int unsigned cycles = 0;
	src_item_t   src_items[$];
	rx_style_t   rx_style = RX_OPEN;
	int          rx_left = 0;

	string       op_chars = "(){}[]+-*/;,.=><!";
	string       keywords[8] = '{"for", "while", "return", "new", "delete", "null", "true",
		"false"};
	logic [7:0]  blanks[5] = '{CH_SPACE, CH_TAB, CH_FF, CH_VT, CH_LF};

	stt_in_if  in_ch();
	stt_out_if out_ch();

	source_text_tokenizer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	token_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$error("run did not finish within %0d cycles", CYCLE_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// token sink: switches at random between stall styles
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_style = rx_style_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 200);
		end else begin
			rx_left--;
		end
		case (rx_style)
			RX_OPEN:   out_ch.ready <= 1'b1;
			RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
			default:   out_ch.ready <= (rx_left % 8) < 5;
		endcase
	end

	task automatic put(input logic [7:0] c);
		src_items.insert(src_items.size(), src_item_t'{c, 1'b0});
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endtask

	task automatic put_eos();
		src_items.insert(src_items.size(), src_item_t'{8'($urandom_range(0, 255)), 1'b1});
	endtask

	function automatic logic [7:0] pick_byte(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		logic [7:0] v;
		do
			v = 8'($urandom_range(0, 255));
		while (v == a || v == b || v == c);
		return v;
	endfunction

	function automatic logic [7:0] ident_char(input bit first);
		int r;
		r = first ? 0 : $urandom_range(0, 99);
		// letters of both cases, then digits, then underscore
		if (r < 60)
			return 8'($urandom_range(0, 1) ? $urandom_range(65, 90) : $urandom_range(97, 122));
		else if (r < 85)
			return 8'($urandom_range(48, 57));
		return CH_UNDER;
	endfunction

	// one well-formed lexeme with random content; neighbors may merge into one token
	task automatic add_token();
		int n;
		int r;
		string w;
		n = $urandom_range(0, 99);
		if (n < 15) begin
			w = keywords[$urandom_range(0, 7)];
			// the real keywords, or near misses around them
			case ($urandom_range(0, 5))
				0: w = {w, "s"};
				1: w = w.substr(0, w.len() - 2);
				2: w[0] = w[0] - 8'h20;
				default: ;
			endcase
			put_text(w);
		end else if (n < 30) begin
			put(ident_char(1'b1));
			repeat ($urandom_range(0, 9))
				put(ident_char(1'b0));
		end else if (n < 45) begin
			put(8'(8'h30 + $urandom_range(0, 9)));
			repeat ($urandom_range(0, 6)) begin
				r = $urandom_range(0, 9);
				if (r < 7)
					put(8'(8'h30 + $urandom_range(0, 9)));
				else
					put(r < 9 ? CH_UNDER : CH_DOT);
			end
		end else if (n < 55) begin
			put(CH_TICK);
			repeat ($urandom_range(0, 8))
				put(pick_byte(CH_TICK, CH_TICK, CH_TICK));
			put(CH_TICK);
		end else if (n < 70) begin
			put(op_chars[$urandom_range(0, op_chars.len() - 1)]);
		end else if (n < 80) begin
			repeat ($urandom_range(1, 3))
				put(blanks[$urandom_range(0, 4)]);
		end else if (n < 86) begin
			put(CH_AT);
			if ($urandom_range(0, 3) != 0) begin
				put(pick_byte(CH_AT, CH_LF, CH_CR));
				repeat ($urandom_range(0, 10))
					put(pick_byte(CH_LF, CH_CR, CH_LF));
			end
			put($urandom_range(0, 1) ? CH_LF : CH_CR);
		end else if (n < 92) begin
			put(CH_AT);
			put(CH_AT);
			repeat ($urandom_range(0, 12)) begin
				// a lone marker is always followed by something else
				if ($urandom_range(0, 7) == 0)
					put(CH_AT);
				put(pick_byte(CH_AT, CH_AT, CH_AT));
			end
			put(CH_AT);
			put(CH_AT);
		end else begin
			put(pick_byte(CH_NUL, CH_AT, CH_TICK));
		end
	endtask

	initial begin
		src_item_t it;
		int burst_left;
		int gap;
		int drain_at;
		int waited;

		in_ch.valid <= 1'b0;
		in_ch.char_byte <= 8'h00;
		in_ch.end_mark <= 1'b0;
		arst_n <= 1'b0;

		// directed: every operator, unknown bytes, a string holding nul and 0xff,
		// and an underscore that stops a dot from making a float
		put_text("(){}[]+-*/;,.=><!");
		put(8'hff);
		put(CH_CR);
		put(CH_TICK);
		put(CH_NUL);
		put(8'hff);
		put(CH_TICK);
		put_text("9_.");

		while (src_items.size() < STREAM_LEN)
			add_token();

		// the stream ends once per run, in a randomly chosen state
		case ($urandom_range(0, 3))
			0: begin
				add_token();
				put_eos();
			end
			1: begin
				add_token();
				put(CH_NUL);
			end
			2: begin
				put(CH_TICK);
				put_text("ab");
				put_eos();
			end
			default: begin
				put_text("@@ x");
				put_eos();
			end
		endcase
		// everything after the end of stream is dropped
		repeat (TAIL_ITEMS) begin
			it.ch = 8'($urandom_range(0, 255));
			it.eos = 1'($urandom_range(0, 1));
			src_items.insert(src_items.size(), it);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		burst_left = 0;
		drain_at = $urandom_range(300, 900);
		foreach (src_items[i]) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap != 0) begin
					in_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			if (i == drain_at) begin
				// hold off until every result owed so far has been taken
				in_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
			in_ch.valid <= 1'b1;
			in_ch.char_byte <= src_items[i].ch;
			in_ch.end_mark <= src_items[i].eos;
			@(posedge clk);
			while (!in_ch.ready)
				@(posedge clk);
			burst_left--;
		end
		in_ch.valid <= 1'b0;

		@(posedge clk);
		waited = 0;
		while (pending != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		if (pending != 0)
			$error("%0d expected results never arrived", pending);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/stt_pkg.sv
rtl/stt_if.sv
rtl/stt_front.sv
rtl/stt_queue.sv
rtl/stt_back.sv
rtl/source_text_tokenizer.sv
bench/token_checker.sv
bench/tb_source_text_tokenizer.sv
